// ----- sv/dcs_pkg.sv -----
// Shared types, widths and helper functions for the dominant color similarity block.
// Depends on nothing; every other file imports it.
package dcs_pkg;

    // Fixed-point formats
    localparam int SHARE_FRAC_BITS   = 16;
    localparam int CHANNEL_FRAC_BITS = 4;

    // Field and datapath widths
    localparam int CH_W    = 13;
    localparam int DIFF_W  = CH_W + 1;
    localparam int MAG_W   = CH_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int THR_W   = 24;
    localparam int SHARE_W = SHARE_FRAC_BITS + 1;
    localparam int MUL_W   = SHARE_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CNT_W   = $clog2(SHARE_FRAC_BITS);

    // APB register map
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_LUV_MODE      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RGB_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LUV_THRESHOLD = 2'd2;

    // 1.0 in share format
    localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1) << SHARE_FRAC_BITS;

    // Threshold reset values: 80.0 and 200.0 in squared channel units
    localparam logic [THR_W-1:0] RGB_THR_RESET = THR_W'(80 << (2 * CHANNEL_FRAC_BITS));
    localparam logic [THR_W-1:0] LUV_THR_RESET = THR_W'(200 << (2 * CHANNEL_FRAC_BITS));

    // Configuration as seen by the datapath
    typedef struct packed {
        logic             luv_mode;
        logic [THR_W-1:0] rgb_threshold;
        logic [THR_W-1:0] luv_threshold;
    } cfg_t;

    // Color term unit request and status
    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] distance;
        logic [THR_W-1:0]  thr;
    } term_cmd_t;

    typedef struct packed {
        logic               done;
        logic [SHARE_W-1:0] term;
    } term_stat_t;

    // Absolute difference of two signed channels
    function automatic logic [MAG_W-1:0] chan_mag(logic signed [CH_W-1:0] a,
                                                  logic signed [CH_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

    // Saturate a share at 1.0
    function automatic logic [SHARE_W-1:0] clamp_share(logic [SHARE_W-1:0] v);
        return (v > SHARE_ONE) ? SHARE_ONE : v;
    endfunction

endpackage

// ----- sv/dcs_if.sv -----
// Stream interfaces for the color pair requests and the similarity results.
// Depends on dcs_pkg.
interface dcs_pair_if;
    import dcs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [CH_W-1:0] first_ch0;
    logic signed [CH_W-1:0] first_ch1;
    logic signed [CH_W-1:0] first_ch2;
    logic signed [CH_W-1:0] second_ch0;
    logic signed [CH_W-1:0] second_ch1;
    logic signed [CH_W-1:0] second_ch2;
    logic [SHARE_W-1:0]     first_share;
    logic [SHARE_W-1:0]     second_share;
    logic                   last_pair;

    modport source (
        output valid, first_ch0, first_ch1, first_ch2,
               second_ch0, second_ch1, second_ch2,
               first_share, second_share, last_pair,
        input  ready
    );

    modport sink (
        input  valid, first_ch0, first_ch1, first_ch2,
               second_ch0, second_ch1, second_ch2,
               first_share, second_share, last_pair,
        output ready
    );
endinterface

interface dcs_sim_if;
    import dcs_pkg::*;

    logic               valid;
    logic               ready;
    logic [SHARE_W-1:0] similarity;

    modport source (output valid, similarity, input ready);
    modport sink   (input valid, similarity, output ready);
endinterface

// ----- sv/dcs_regs.sv -----
// APB configuration registers: color space select and the two distance thresholds.
// Depends on dcs_pkg.
module dcs_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [dcs_pkg::ADDR_W-1:0] paddr,
    input  logic [dcs_pkg::DATA_W-1:0] pwdata,
    output logic [dcs_pkg::DATA_W-1:0] prdata,
    output dcs_pkg::cfg_t             cfg
);
    import dcs_pkg::*;

    logic                 luv_mode_reg;
    logic [THR_W-1:0]     rgb_thr_reg;
    logic [THR_W-1:0]     luv_thr_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luv_mode_reg <= 1'b0;
            rgb_thr_reg  <= RGB_THR_RESET;
            luv_thr_reg  <= LUV_THR_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LUV_MODE:      luv_mode_reg <= pwdata[0];
                REG_RGB_THRESHOLD: rgb_thr_reg  <= pwdata[THR_W-1:0];
                REG_LUV_THRESHOLD: luv_thr_reg  <= pwdata[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_LUV_MODE:      prdata = DATA_W'(luv_mode_reg);
            REG_RGB_THRESHOLD: prdata = DATA_W'(rgb_thr_reg);
            REG_LUV_THRESHOLD: prdata = DATA_W'(luv_thr_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.luv_mode      = luv_mode_reg;
    assign cfg.rgb_threshold = rgb_thr_reg;
    assign cfg.luv_threshold = luv_thr_reg;

endmodule

// ----- sv/dcs_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on dcs_pkg.
module dcs_mul (
    input  logic                      clk,
    input  logic                      en,
    input  logic [dcs_pkg::MUL_W-1:0]  a,
    input  logic [dcs_pkg::MUL_W-1:0]  b,
    output logic [dcs_pkg::PROD_W-1:0] prod
);
    import dcs_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // Capture one product per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- sv/dcs_term.sv -----
// Color term unit: 1 - d/T in share format via a restoring divider, one quotient
// bit per cycle. Depends on dcs_pkg.
module dcs_term (
    input  logic                clk,
    input  logic                rst_n,
    input  dcs_pkg::term_cmd_t  cmd,
    output dcs_pkg::term_stat_t stat
);
    import dcs_pkg::*;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [THR_W-1:0]           rem_reg, rem_next;
    logic [THR_W-1:0]           div_reg, div_next;
    logic [SHARE_FRAC_BITS-1:0] quo_reg, quo_next;
    logic [SHARE_W-1:0]         term_reg, term_next;
    logic [THR_W:0]             shifted;
    logic [THR_W:0]             trial;

    // One restoring step
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        term_next = term_reg;

        if (cmd.start)
        begin
            cnt_next = '0;
            quo_next = '0;
            div_next = cmd.thr;
            rem_next = cmd.thr - cmd.distance[THR_W-1:0];
            // Outside the threshold: no color credit
            if (cmd.distance > DIST_W'(cmd.thr))
            begin
                term_next = '0;
                done_next = 1'b1;
            end
            // Identical colors, also covers a zero threshold
            else if (cmd.distance == '0)
            begin
                term_next = SHARE_ONE;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!trial[THR_W])
            begin
                rem_next = trial[THR_W-1:0];
                quo_next = {quo_reg[SHARE_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[THR_W-1:0];
                quo_next = {quo_reg[SHARE_FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SHARE_FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                term_next = SHARE_W'(quo_next);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Division datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        term_reg <= term_next;
    end

    assign stat.done = done_reg;
    assign stat.term = term_reg;

endmodule

// ----- sv/dominant_color_similarity.sv -----
// Dominant color similarity accumulator top: sequencer, APB registers (dcs_regs),
// shared multiplier (dcs_mul), color term divider (dcs_term); needs dcs_pkg, dcs_if.
//
// Usage:
//   pair   - request channel, one matched pair of dominant colors per request:
//            three signed channels per color (4 fraction bits), two Q16 shares
//            and last_pair.
//   result - one Q16 similarity per descriptor comparison, sent after the request
//            that carries last_pair; the running sum then restarts at zero.
//   APB    - luv_mode at 0x0, rgb_threshold at 0x4, luv_threshold at 0x8;
//            write only while no request is in flight.
// Timing: the color term divider is skipped when the distance is zero or above the
//   threshold. Otherwise the cost is the divider, one quotient bit per cycle over 16
//   bits; every request also takes five passes through the shared multiplier.
//   pair.ready is high only while idle; a result is loaded at the same edge as the
//   sum update of the last pair.
// Reset: clears the running sum and the output valid, and loads the default
//   thresholds (80.0 RGB, 200.0 LUV) with RGB space selected.
// Stall: a result is held in an output register until taken; the next request
//   is accepted meanwhile, and a later last pair waits for the register to free.
module dominant_color_similarity (
    input  logic                       clk,
    input  logic                       rst_n,
    dcs_pair_if.sink                   pair,
    dcs_sim_if.source                  result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dcs_pkg::ADDR_W-1:0] paddr,
    input  logic [dcs_pkg::DATA_W-1:0] pwdata,
    output logic [dcs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import dcs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_WGT   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_TERM  = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;

    cfg_t        cfg;
    term_cmd_t   term_cmd;
    term_stat_t  term_stat;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          step_reg, step_next;
    logic [MAG_W-1:0]    mag_reg [3];
    logic [SHARE_W-1:0]  wa_reg;
    logic [SHARE_W-1:0]  lo_reg;
    logic                last_reg;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [SHARE_W-1:0]  wgt_reg;
    logic [SHARE_W-1:0]  sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [SHARE_W-1:0]  out_sim_reg;

    logic                accept;
    logic                mul_en;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic [SHARE_W-1:0]  add_term;
    logic [SHARE_W:0]    sum_wide;
    logic [SHARE_W-1:0]  sum_sat;
    logic                emit;
    logic [SHARE_W-1:0]  p1, p2;

    dcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    dcs_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    dcs_term u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (term_cmd),
        .stat  (term_stat)
    );

    assign accept     = pair.valid && pair.ready;
    assign pair.ready = (state_reg == ST_IDLE);

    // Clamp the shares as they arrive
    assign p1 = clamp_share(pair.first_share);
    assign p2 = clamp_share(pair.second_share);

    // Latch the request operands, the pair weight, the distance and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg[0] <= chan_mag(pair.first_ch0, pair.second_ch0);
            mag_reg[1] <= chan_mag(pair.first_ch1, pair.second_ch1);
            mag_reg[2] <= chan_mag(pair.first_ch2, pair.second_ch2);
            wa_reg     <= SHARE_ONE - ((p1 > p2) ? (p1 - p2) : (p2 - p1));
            lo_reg     <= (p1 < p2) ? p1 : p2;
            last_reg   <= pair.last_pair;
        end
        if (state_reg == ST_START)
        begin
            wgt_reg <= prod[SHARE_FRAC_BITS +: SHARE_W];
        end
        dist_reg <= dist_next;
        if (emit)
        begin
            out_sim_reg <= sum_sat;
        end
    end

    // Scaled pair contribution and saturated running sum
    assign add_term = prod[SHARE_FRAC_BITS +: SHARE_W];
    assign sum_wide = {1'b0, sum_reg} + {1'b0, add_term};
    assign sum_sat  = (sum_wide > (SHARE_W + 1)'(SHARE_ONE)) ? SHARE_ONE
                                                             : sum_wide[SHARE_W-1:0];
    assign emit     = (state_reg == ST_ACC) && last_reg && (!out_valid_reg || result.ready);

    // Color term request
    assign term_cmd.start    = (state_reg == ST_START);
    assign term_cmd.distance = dist_reg;
    assign term_cmd.thr      = cfg.luv_mode ? cfg.luv_threshold : cfg.rgb_threshold;

    // Sequencer: operand selection for the shared multiplier and next state
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        dist_next      = dist_reg;
        sum_next       = sum_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        out_valid_next = out_valid_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                dist_next = '0;
                if (accept)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(mag_reg[step_reg]);
                mul_b  = MUL_W'(mag_reg[step_reg]);
                if (step_reg != '0)
                begin
                    dist_next = dist_reg + DIST_W'(prod[SQ_W-1:0]);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd2)
                begin
                    state_next = ST_WGT;
                end
            end
            ST_WGT:
            begin
                mul_en     = 1'b1;
                mul_a      = wa_reg;
                mul_b      = lo_reg;
                dist_next  = dist_reg + DIST_W'(prod[SQ_W-1:0]);
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                // Scale the color term by the pair weight
                if (term_stat.done)
                begin
                    mul_en     = 1'b1;
                    mul_a      = term_stat.term;
                    mul_b      = wgt_reg;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (!last_reg)
                begin
                    sum_next   = sum_sat;
                    state_next = ST_IDLE;
                end
                else if (emit)
                begin
                    sum_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.similarity = out_sim_reg;

endmodule

// ----- sv/dcs_checker.sv -----
// Port-level checks for the dominant color similarity block, bound to the top level.
// Depends on dcs_pkg and dominant_color_similarity.
module dcs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dcs_pkg::SHARE_W-1:0] similarity,
    input logic                        pready
);
    import dcs_pkg::*;

    // Saturated sum never exceeds 1.0
    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (similarity <= SHARE_ONE))
        else $error("similarity above 1.0");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(similarity)))
        else $error("stalled result changed");

    // Busy after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    // A result never follows a request in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result too early");

    // No wait states on the configuration port
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind dominant_color_similarity dcs_checker u_dcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pair.valid),
    .in_ready   (pair.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .similarity (result.similarity),
    .pready     (pready)
);

// ----- tb/sv/tb_dominant_color_similarity.sv -----
`timescale 1ns / 1ps
// Testbench for dominant_color_similarity: directed and random color pair requests,
// APB register writes and readback, similarity checked against an in-bench predictor.
// Depends on dcs_pkg, dcs_if and the dominant_color_similarity RTL.
module tb_dominant_color_similarity;
    import dcs_pkg::*;

    localparam logic [63:0] ONE64        = 64'd1 << SHARE_FRAC_BITS;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          PHASE_ITEMS  = 190;
    localparam int          SHOWN_ERRORS = 10;

    typedef struct packed {
        logic signed [CH_W-1:0] f0;
        logic signed [CH_W-1:0] f1;
        logic signed [CH_W-1:0] f2;
        logic signed [CH_W-1:0] s0;
        logic signed [CH_W-1:0] s1;
        logic signed [CH_W-1:0] s2;
        logic [SHARE_W-1:0]     p1;
        logic [SHARE_W-1:0]     p2;
        logic                   last;
    } pair_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dcs_pair_if pair_if ();
    dcs_sim_if  sim_if ();

    dominant_color_similarity dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pair    (pair_if),
        .result  (sim_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: register copies and the running similarity sum
    logic               cfg_luv;
    logic [THR_W-1:0]   cfg_rgb_thr;
    logic [THR_W-1:0]   cfg_luv_thr;
    logic [63:0]        model_sum;
    logic [SHARE_W-1:0] expected_sims[$];
    logic [SHARE_W-1:0] want_sim;
    int                 error_count;
    int                 stall_left;
    bit                 drive_idle;

    // Free-running clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("mismatch: %s", msg);
    endtask

    // Squared difference of two signed channels
    function automatic logic [63:0] sq_delta(logic signed [CH_W-1:0] a,
                                             logic signed [CH_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return 64'(d * d);
    endfunction

    // Amount one pair adds to the similarity sum under the current registers
    function automatic logic [63:0] pair_gain(pair_t p);
        logic [63:0] distance;
        logic [63:0] thr;
        logic [63:0] term;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] gap;
        logic [63:0] lo;
        logic [63:0] wgt;
        distance = sq_delta(p.f0, p.s0) + sq_delta(p.f1, p.s1) + sq_delta(p.f2, p.s2);
        thr  = cfg_luv ? 64'(cfg_luv_thr) : 64'(cfg_rgb_thr);
        if (distance > thr)
            term = 0;
        else if (thr == 0)
            term = ONE64;
        else
            term = ((thr - distance) << SHARE_FRAC_BITS) / thr;
        // saturate shares at 1.0
        a   = (64'(p.p1) > ONE64) ? ONE64 : 64'(p.p1);
        b   = (64'(p.p2) > ONE64) ? ONE64 : 64'(p.p2);
        gap = (a > b) ? a - b : b - a;
        lo  = (a < b) ? a : b;
        wgt = ((ONE64 - gap) * lo) >> SHARE_FRAC_BITS;
        return (term * wgt) >> SHARE_FRAC_BITS;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_LUV_MODE:      return DATA_W'(cfg_luv);
            REG_RGB_THRESHOLD: return DATA_W'(cfg_rgb_thr);
            REG_LUV_THRESHOLD: return DATA_W'(cfg_luv_thr);
            default:           return '0;
        endcase
    endfunction

    function automatic pair_t mk_pair(int f0, int f1, int f2, int s0, int s1, int s2,
                                      int p1, int p2, bit last);
        pair_t p;
        p.f0   = CH_W'(f0);
        p.f1   = CH_W'(f1);
        p.f2   = CH_W'(f2);
        p.s0   = CH_W'(s0);
        p.s1   = CH_W'(s1);
        p.s2   = CH_W'(s2);
        p.p1   = SHARE_W'(p1);
        p.p2   = SHARE_W'(p2);
        p.last = last;
        return p;
    endfunction

    // Channel near a base value, clipped to the signed field range
    function automatic logic signed [CH_W-1:0] near_chan(logic signed [CH_W-1:0] base,
                                                         int spread);
        int v;
        v = int'(base) + int'($urandom_range(2 * spread)) - spread;
        if (v > 4095)
            v = 4095;
        if (v < -4096)
            v = -4096;
        return CH_W'(v);
    endfunction

    function automatic logic [SHARE_W-1:0] rand_share();
        case ($urandom_range(9))
            0:       return '0;
            1:       return SHARE_ONE;
            2:       return SHARE_W'($urandom_range(131071, 65537));
            default: return SHARE_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic pair_t rand_pair(bit last);
        pair_t p;
        int    spread;
        p.f0 = CH_W'($urandom);
        p.f1 = CH_W'($urandom);
        p.f2 = CH_W'($urandom);
        case ($urandom_range(5))
            0:       spread = 0;
            1:       spread = 4;
            2:       spread = 64;
            3:       spread = 160;
            4:       spread = 400;
            default: spread = -1;
        endcase
        if (spread < 0)
        begin
            p.s0 = CH_W'($urandom);
            p.s1 = CH_W'($urandom);
            p.s2 = CH_W'($urandom);
        end
        else
        begin
            p.s0 = near_chan(p.f0, spread);
            p.s1 = near_chan(p.f1, spread);
            p.s2 = near_chan(p.f2, spread);
        end
        p.p1   = rand_share();
        p.p2   = ($urandom_range(5) == 0) ? p.p1 : rand_share();
        p.last = last;
        return p;
    endfunction

    // Send one pair request; returns at the accepting edge with valid still high
    task automatic send_pair(pair_t p);
        if (drive_idle && $urandom_range(99) < 11)
        begin
            pair_if.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
        pair_if.valid        <= 1'b1;
        pair_if.first_ch0    <= p.f0;
        pair_if.first_ch1    <= p.f1;
        pair_if.first_ch2    <= p.f2;
        pair_if.second_ch0   <= p.s0;
        pair_if.second_ch1   <= p.s1;
        pair_if.second_ch2   <= p.s2;
        pair_if.first_share  <= p.p1;
        pair_if.second_share <= p.p2;
        pair_if.last_pair    <= p.last;
        @(posedge clk);
        while (!pair_if.ready)
            @(posedge clk);
        // accepted: advance the predicted sum
        model_sum = model_sum + pair_gain(p);
        if (model_sum > ONE64)
            model_sum = ONE64;
        if (p.last)
        begin
            expected_sims = {expected_sims, SHARE_W'(model_sum)};
            model_sum = 0;
        end
    endtask

    // Drop valid and wait until the block is idle
    task automatic settle();
        pair_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_sims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LUV_MODE:      cfg_luv     = data[0];
            REG_RGB_THRESHOLD: cfg_rgb_thr = data[THR_W-1:0];
            REG_LUV_THRESHOLD: cfg_luv_thr = data[THR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic cfg_read_check(logic [REG_IDX_W-1:0] idx);
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== reg_value(idx))
            note_error($sformatf("register %0d read %0h, expected %0h",
                                 idx, got, reg_value(idx)));
    endtask

    // Program all three registers with junk in the unused upper bits, then read back
    task automatic set_space(bit mode, logic [THR_W-1:0] rgb, logic [THR_W-1:0] luv);
        settle();
        cfg_write(REG_LUV_MODE, {31'($urandom), mode});
        cfg_write(REG_RGB_THRESHOLD, {8'($urandom), rgb});
        cfg_write(REG_LUV_THRESHOLD, {8'($urandom), luv});
        cfg_read_check(REG_LUV_MODE);
        cfg_read_check(REG_RGB_THRESHOLD);
        cfg_read_check(REG_LUV_THRESHOLD);
    endtask

    task automatic test_reset_values();
        cfg_read_check(REG_LUV_MODE);
        cfg_read_check(REG_RGB_THRESHOLD);
        cfg_read_check(REG_LUV_THRESHOLD);
    endtask

    // Default RGB space: channel and share extremes, boundary, saturation
    task automatic test_rgb_defaults();
        send_pair(mk_pair(0, 0, 0, 0, 0, 0, 65536, 65536, 1));
        send_pair(mk_pair(-4096, -4096, -4096, 4095, 4095, 4095, 65536, 65536, 1));
        send_pair(mk_pair(4095, 4095, 4095, 4095, 4095, 4095, 32768, 32768, 1));
        // distance exactly at the threshold, then just inside
        send_pair(mk_pair(128, 64, 0, 0, 0, 0, 65536, 65536, 1));
        send_pair(mk_pair(127, 64, 0, 0, 0, 0, 65536, 65536, 1));
        // share above one and share of zero
        send_pair(mk_pair(10, -20, 30, 10, -20, 30, 131071, 65536, 1));
        send_pair(mk_pair(5, 5, 5, 5, 5, 5, 0, 65536, 1));
        // sum saturates at one across a descriptor
        send_pair(mk_pair(1, 2, 3, 1, 2, 3, 65536, 65536, 0));
        send_pair(mk_pair(-7, 0, 7, -7, 0, 7, 65536, 65536, 0));
        send_pair(mk_pair(100, 100, 100, 101, 99, 100, 60000, 65000, 1));
    endtask

    task automatic test_zero_threshold();
        set_space(1'b0, '0, LUV_THR_RESET);
        send_pair(mk_pair(300, -300, 0, 300, -300, 0, 40000, 50000, 1));
        send_pair(mk_pair(300, -300, 0, 301, -300, 0, 40000, 50000, 1));
        set_space(1'b1, RGB_THR_RESET, '0);
        send_pair(mk_pair(-1, -1, -1, -1, -1, -1, 65536, 65536, 1));
        send_pair(mk_pair(-1, -1, -1, -1, -1, 0, 65536, 65536, 1));
    endtask

    task automatic test_luv_space();
        set_space(1'b1, RGB_THR_RESET, LUV_THR_RESET);
        send_pair(mk_pair(160, 160, 0, 0, 0, 0, 65536, 65536, 1));
        send_pair(mk_pair(159, 160, 0, 0, 0, 0, 65536, 65536, 0));
        send_pair(mk_pair(-50, 20, 3, -40, 25, 0, 20000, 30000, 1));
    endtask

    task automatic test_full_threshold();
        set_space(1'b0, 24'hFFFFFF, 24'hFFFFFF);
        send_pair(mk_pair(-4096, -4096, -4096, 4095, 4095, 4095, 65536, 65536, 1));
        send_pair(mk_pair(4095, 0, 0, 0, 0, 0, 65536, 65536, 1));
    endtask

    // Random descriptors over several register settings
    task automatic test_random_stream();
        int sent;
        int run_len;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_space(1'b0, RGB_THR_RESET, LUV_THR_RESET);
                1: set_space(1'b1, THR_W'($urandom), LUV_THR_RESET);
                2: set_space(1'b0, THR_W'($urandom_range(1, 1 << 18)), THR_W'($urandom));
                3: set_space(1'b0, 24'hFFFFFF, THR_W'($urandom));
                4: set_space(1'b1, THR_W'($urandom), '0);
                5: set_space(1'b0, '0, THR_W'($urandom));
                6: set_space(1'b1, '0, 24'hFFFFFF);
                default: set_space(1'($urandom), THR_W'($urandom_range(1, 200000)),
                                   THR_W'($urandom_range(1, 200000)));
            endcase
            // one phase runs without any idling on either side
            drive_idle = (phase != 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run_len = $urandom_range(1, 8);
                for (int k = 0; k < run_len; k++)
                    send_pair(rand_pair(k == run_len - 1));
                sent += run_len;
            end
        end
        drive_idle = 1'b1;
    endtask

    // Result sink: random short stalls and occasional long ones
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            sim_if.ready  <= 1'b0;
        end
        else if (drive_idle && $urandom_range(999) < 2)
        begin
            stall_left    <= $urandom_range(30, 60);
            sim_if.ready  <= 1'b0;
        end
        else
            sim_if.ready <= !(drive_idle && $urandom_range(99) < 3);
    end

    // Compare each accepted similarity with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && sim_if.valid && sim_if.ready)
        begin
            if (expected_sims.size() == 0)
                note_error($sformatf("unexpected similarity %0d", sim_if.similarity));
            else
            begin
                want_sim = expected_sims.pop_front();
                if (sim_if.similarity !== want_sim)
                    note_error($sformatf("similarity %0d, expected %0d",
                                         sim_if.similarity, want_sim));
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        pair_if.valid        = 1'b0;
        pair_if.first_ch0    = '0;
        pair_if.first_ch1    = '0;
        pair_if.first_ch2    = '0;
        pair_if.second_ch0   = '0;
        pair_if.second_ch1   = '0;
        pair_if.second_ch2   = '0;
        pair_if.first_share  = '0;
        pair_if.second_share = '0;
        pair_if.last_pair    = 1'b0;
        sim_if.ready         = 1'b0;
        stall_left           = 0;
        error_count          = 0;
        drive_idle           = 1'b1;
        cfg_luv              = 1'b0;
        cfg_rgb_thr          = RGB_THR_RESET;
        cfg_luv_thr          = LUV_THR_RESET;
        model_sum            = 0;

        // Hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_rgb_defaults();
        test_zero_threshold();
        test_luv_space();
        test_full_threshold();
        test_random_stream();

        settle();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
